// File: src/assert_macros.svh
// Assertion macros shared by the decimal text converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define DTTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DTTI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/dtti_pkg.sv
// Types, codes and helper functions of the decimal text to integer converter.
package dtti_pkg;

    // Target kinds; bit 2 set means a signed kind.
    localparam logic [2:0] KIND_U8  = 3'd0;
    localparam logic [2:0] KIND_U16 = 3'd1;
    localparam logic [2:0] KIND_U32 = 3'd2;
    localparam logic [2:0] KIND_U64 = 3'd3;
    localparam logic [2:0] KIND_I8  = 3'd4;
    localparam logic [2:0] KIND_I16 = 3'd5;
    localparam logic [2:0] KIND_I32 = 3'd6;
    localparam logic [2:0] KIND_I64 = 3'd7;

    // Character codes of the grammar.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Result error codes; the sticky mark uses the same encoding.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_BAD   = 2'd2,
        ERR_RANGE = 2'd3
    } t_err;

    // One input item as held in the input register.
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic [2:0] target_kind;
        logic       last;
    } t_in_item;

    // Field state captured on the last character, handed to the range check.
    typedef struct packed {
        logic [63:0] acc;
        logic        neg;
        logic        saw_digit;
        t_err        sticky;
        logic [2:0]  kind;
    } t_field_snap;

    // Largest magnitude allowed for a kind and sign.
    function automatic logic [63:0] limit_for(input logic [2:0] kind, input logic neg);
        logic [63:0] lim;
        case (kind)
            KIND_U8:  lim = 64'h0000_0000_0000_00FF;
            KIND_U16: lim = 64'h0000_0000_0000_FFFF;
            KIND_U32: lim = 64'h0000_0000_FFFF_FFFF;
            KIND_U64: lim = 64'hFFFF_FFFF_FFFF_FFFF;
            KIND_I8:  lim = 64'h0000_0000_0000_007F;
            KIND_I16: lim = 64'h0000_0000_0000_7FFF;
            KIND_I32: lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
            KIND_I64: lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            default:  lim = 64'h0;
        endcase
        return lim;
    endfunction

endpackage

// File: src/dtti_step.sv
// Per-character accumulation of one decimal field and its sticky error mark.
`include "assert_macros.svh"

module dtti_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  dtti_pkg::t_in_item   i_in,
    input  logic                 i_fin_free,
    output logic                 o_take,
    output logic                 o_snap_valid,
    output dtti_pkg::t_field_snap o_snap
);

    logic [63:0]     r_acc;
    logic            r_neg;
    logic            r_saw;
    dtti_pkg::t_err  r_sticky;
    logic            r_at_start;
    logic [2:0]      r_kind;

    logic [63:0]     n_acc;
    logic            n_neg;
    logic            n_saw;
    dtti_pkg::t_err  n_sticky;
    logic [2:0]      n_kind;

    logic            is_minus;
    logic            is_digit;
    logic            is_bad;
    logic [67:0]     prod;
    logic            ovf;

    // A last item needs room in the range-check stage; other items always move on.
    assign o_take = i_in_valid && (!i_in.last || i_fin_free);

    // Classify the character and form acc*10+digit with carry-out as overflow.
    always_comb begin
        n_kind   = r_at_start ? i_in.target_kind : r_kind;
        is_minus = i_in.has_char && r_at_start && (i_in.char_code == dtti_pkg::CHAR_MINUS)
                   && n_kind[2];
        is_digit = i_in.has_char && !is_minus
                   && (i_in.char_code >= dtti_pkg::CHAR_ZERO)
                   && (i_in.char_code <= dtti_pkg::CHAR_NINE);
        is_bad   = i_in.has_char && !is_minus && !is_digit;
        prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                   + {64'b0, i_in.char_code[3:0]};
        ovf      = |prod[67:64];

        n_acc    = r_acc;
        n_sticky = r_sticky;
        if (is_bad) begin
            n_sticky = dtti_pkg::ERR_BAD;
        end else if (is_digit && (r_sticky == dtti_pkg::ERR_NONE)) begin
            if (ovf) begin
                n_sticky = dtti_pkg::ERR_RANGE;
            end else begin
                n_acc = prod[63:0];
            end
        end
        n_saw = r_saw | is_digit;
        n_neg = r_neg | is_minus;
    end

    // Snapshot of the finished field.
    assign o_snap_valid     = o_take && i_in.last;
    assign o_snap.acc       = n_acc;
    assign o_snap.neg       = n_neg;
    assign o_snap.saw_digit = n_saw;
    assign o_snap.sticky    = n_sticky;
    assign o_snap.kind      = n_kind;

    // Field state; cleared after the last item of a field.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_snap_valid) begin
            r_acc      <= 64'h0;
            r_neg      <= 1'b0;
            r_saw      <= 1'b0;
            r_sticky   <= dtti_pkg::ERR_NONE;
            r_at_start <= 1'b1;
            r_kind     <= dtti_pkg::KIND_U8;
        end else if (o_take) begin
            r_acc      <= n_acc;
            r_neg      <= n_neg;
            r_saw      <= n_saw;
            r_sticky   <= n_sticky;
            r_at_start <= 1'b0;
            r_kind     <= n_kind;
        end
    end

    `DTTI_ASSERT_ALWAYS(a_start_clean, r_at_start |-> (r_acc == 64'h0 && !r_saw && !r_neg && r_sticky == dtti_pkg::ERR_NONE), "field start with leftover state")
    `DTTI_ASSERT(a_last_clears, o_snap_valid |=> r_at_start, "state not cleared after last item")

endmodule

// File: src/dtti_finish.sv
// Range check, sign application and the result output register.
`include "assert_macros.svh"

module dtti_finish (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_snap_valid,
    input  dtti_pkg::t_field_snap i_snap,
    output logic                  o_fin_free,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [63:0]           o_value,
    output logic                  o_ok,
    output dtti_pkg::t_err        o_err
);

    logic                  r_fin_valid;
    dtti_pkg::t_field_snap r_fin;
    logic                  r_out_valid;
    logic [63:0]           r_value;
    logic                  r_ok;
    dtti_pkg::t_err        r_err;

    logic                  out_free;
    logic [63:0]           n_value;
    logic                  n_ok;
    dtti_pkg::t_err        n_err;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_fin_free = !r_fin_valid || out_free;

    // Snapshot register between the accumulator and the range check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= i_snap_valid || (r_fin_valid && !out_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid) begin
            r_fin <= i_snap;
        end
    end

    // Error priority: bad character, then missing digit, then out of range.
    always_comb begin
        n_value = 64'h0;
        n_ok    = 1'b0;
        if (r_fin.sticky == dtti_pkg::ERR_BAD) begin
            n_err = dtti_pkg::ERR_BAD;
        end else if (!r_fin.saw_digit) begin
            n_err = dtti_pkg::ERR_EMPTY;
        end else if ((r_fin.sticky == dtti_pkg::ERR_RANGE)
                     || (r_fin.acc > dtti_pkg::limit_for(r_fin.kind, r_fin.neg))) begin
            n_err = dtti_pkg::ERR_RANGE;
        end else begin
            n_err   = dtti_pkg::ERR_NONE;
            n_ok    = 1'b1;
            n_value = r_fin.neg ? (~r_fin.acc + 64'd1) : r_fin.acc;
        end
    end

    // Result register; a new result loads as soon as the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_fin_valid) begin
            r_value <= n_value;
            r_ok    <= n_ok;
            r_err   <= n_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_ok        = r_ok;
    assign o_err       = r_err;

    `DTTI_ASSERT(a_fail_zero, (r_out_valid && !r_ok) |-> (r_value == 64'h0), "failed result carries a nonzero value")
    `DTTI_ASSERT(a_fin_held, (r_fin_valid && !out_free) |=> r_fin_valid, "pending snapshot dropped while output stalled")

endmodule

// File: src/decimal_text_to_integer_top.sv
// Top level of the decimal text to integer converter.
//
//  channel | direction | tdata           | tuser                          | tlast
//  s       | in        | [7:0] char_code | [0] has_char, [3:1] target_kind | last
//  m       | out       | [63:0] value    | [0] ok, [2:1] error_code        | -
//
// One input transfer is taken every cycle while the result side keeps up.
// After its last character is transferred, a result moves on from the input register:
// the step logic behind the input register loads the range-check register, which loads
// the output register.
// The acc*10+digit add in the step stage and the 64-bit range compare set the clock path.
// Reset clears all valid flags and the field state; no clearing pass is needed.
// A stalled result side holds one result and one pending field; characters keep flowing until a last one waits.

module decimal_text_to_integer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic [3:0]  i_s_tuser,   // [0] has_char, [3:1] target_kind
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] value
    output logic [2:0]  o_m_tuser    // [0] ok, [2:1] error_code
);

    logic                  r_in_valid;
    dtti_pkg::t_in_item    r_in;

    logic                  take;
    logic                  fin_free;
    logic                  snap_valid;
    dtti_pkg::t_field_snap snap;
    logic                  ok;
    dtti_pkg::t_err        err;

    assign o_s_tready = !r_in_valid || take;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.char_code   <= i_s_tdata;
            r_in.has_char    <= i_s_tuser[0];
            r_in.target_kind <= i_s_tuser[3:1];
            r_in.last        <= i_s_tlast;
        end
    end

    dtti_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (r_in_valid),
        .i_in         (r_in),
        .i_fin_free   (fin_free),
        .o_take       (take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    dtti_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_fin_free   (fin_free),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_value      (o_m_tdata),
        .o_ok         (ok),
        .o_err        (err)
    );

    assign o_m_tuser = {err, ok};

endmodule

// File: tb/tb.sv
// Self-checking testbench for the decimal text to integer converter.
`timescale 1ns / 1ps

module tb;
    import dtti_pkg::*;

    localparam int          IDLE_LIMIT = 2000;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    // One converted field as it should leave the result channel.
    typedef struct packed {
        logic [63:0] value;
        logic        ok;
        t_err        err;
    } conv_result_t;

    // One character waiting to be sent; hold marks a pause until all results are in.
    typedef struct {
        t_in_item item;
        bit       hold;
    } queued_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] char_code
    logic [3:0]  s_tuser = 4'd0;     // [0] has_char, [3:1] target_kind
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // [63:0] value
    logic [2:0]  m_tuser;            // [0] ok, [2:1] error_code

    queued_char_t pending_chars[$];
    t_in_item     field_items[$];
    conv_result_t expected_results[$];
    t_in_item     cur_item;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_tick = 0;
    int           stall_mode = 0;
    int           idle_cycles = 0;
    int           mismatches = 0;

    // Converter state as the predictor tracks it.
    logic [63:0] acc_mag = 64'd0;
    logic        neg_seen = 1'b0;
    logic        digit_seen = 1'b0;
    t_err        sticky_err = ERR_NONE;
    logic        field_start = 1'b1;
    logic [2:0]  field_kind = KIND_U8;

    decimal_text_to_integer_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Largest magnitude a kind accepts; the negative side of i32 and i64 is one larger.
    function automatic logic [63:0] magnitude_cap(input logic [2:0] k, input logic neg);
        logic [63:0] cap;
        case (k)
            KIND_U8:  cap = 64'hFF;
            KIND_U16: cap = 64'hFFFF;
            KIND_U32: cap = 64'hFFFF_FFFF;
            KIND_U64: cap = ALL_ONES;
            KIND_I8:  cap = 64'h7F;
            KIND_I16: cap = 64'h7FFF;
            KIND_I32: cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            default:  cap = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
        return cap;
    endfunction

    // Advance the predicted state by one accepted character; a last item yields a result.
    task automatic convert_char(input t_in_item it);
        logic [63:0]  digit;
        logic         first;
        conv_result_t r;
        first = field_start;
        if (first) field_kind = it.target_kind;
        field_start = 1'b0;
        if (it.has_char) begin
            if (first && it.char_code == CHAR_MINUS && field_kind >= KIND_I8) begin
                neg_seen = 1'b1;
            end else if (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE) begin
                digit = 64'(it.char_code - CHAR_ZERO);
                digit_seen = 1'b1;
                if (sticky_err == ERR_NONE) begin
                    if (acc_mag > (ALL_ONES - digit) / 64'd10) sticky_err = ERR_RANGE;
                    else acc_mag = acc_mag * 64'd10 + digit;
                end
            end else begin
                sticky_err = ERR_BAD;
            end
        end
        if (it.last) begin
            r.value = 64'd0;
            r.ok = 1'b0;
            if (sticky_err == ERR_BAD) begin
                r.err = ERR_BAD;
            end else if (!digit_seen) begin
                r.err = ERR_EMPTY;
            end else if (sticky_err == ERR_RANGE ||
                         acc_mag > magnitude_cap(field_kind, neg_seen)) begin
                r.err = ERR_RANGE;
            end else begin
                r.err = ERR_NONE;
                r.ok = 1'b1;
                r.value = neg_seen ? 64'd0 - acc_mag : acc_mag;
            end
            expected_results.push_back(r);
            acc_mag = 64'd0;
            neg_seen = 1'b0;
            digit_seen = 1'b0;
            sticky_err = ERR_NONE;
            field_start = 1'b1;
            field_kind = KIND_U8;
        end
    endtask

    function automatic t_in_item make_item(input logic [7:0] ch, input logic has);
        t_in_item it;
        it.char_code = ch;
        it.has_char = has;
        it.target_kind = 3'($urandom_range(0, 7));
        it.last = 1'b0;
        return it;
    endfunction

    // Close the staged field: kind on its first item, last on its final one.
    task automatic commit_field(input logic [2:0] k, input bit hold);
        queued_char_t qc;
        if (field_items.size() == 0) field_items.push_back(make_item(8'($urandom), 1'b0));
        field_items[0].target_kind = k;
        field_items[field_items.size() - 1].last = 1'b1;
        foreach (field_items[i]) begin
            qc.item = field_items[i];
            qc.hold = hold && (i == 0);
            pending_chars.push_back(qc);
        end
        field_items.delete();
    endtask

    // Stage a text field, optionally with blank items mixed in or one character spoiled.
    task automatic queue_text(input string txt, input logic [2:0] k, input bit blanks,
                              input bit spoil, input bit hold);
        int pos;
        for (int i = 0; i < txt.len(); i++) begin
            if (blanks && $urandom_range(0, 3) == 0)
                field_items.push_back(make_item(8'($urandom), 1'b0));
            field_items.push_back(make_item(txt[i], 1'b1));
        end
        if (blanks && $urandom_range(0, 2) == 0)
            field_items.push_back(make_item(8'($urandom), 1'b0));
        if (spoil && field_items.size() > 0) begin
            pos = $urandom_range(0, field_items.size() - 1);
            field_items[pos].char_code = 8'($urandom);
            field_items[pos].has_char = 1'b1;
        end
        commit_field(k, hold);
    endtask

    // Decimal text for a kind: near its limits, small, wide, too long or zero-padded.
    function automatic string number_text(input logic [2:0] k);
        logic [63:0] cap;
        logic [63:0] mag;
        int          delta;
        bit          neg;
        string       s;
        neg = (k >= KIND_I8) && ($urandom_range(0, 1) == 1);
        cap = magnitude_cap(k, neg);
        case ($urandom_range(0, 4))
            0: begin
                delta = $urandom_range(0, 4) - 2;
                if (cap == ALL_ONES && delta > 0) begin
                    s = $sformatf("1844674407370955161%0d", 5 + delta);
                end else begin
                    mag = cap + 64'(delta);
                    s = $sformatf("%0d", mag);
                end
            end
            1: s = $sformatf("%0d", $urandom_range(0, 300));
            2: begin
                mag = {$urandom, $urandom} >> $urandom_range(0, 63);
                s = $sformatf("%0d", mag);
            end
            3: begin
                s = $sformatf("%0d", $urandom_range(1, 9));
                repeat ($urandom_range(19, 23)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
            default: begin
                s = $sformatf("%0d", $urandom_range(0, 99999));
                repeat ($urandom_range(1, 3)) s = {"0", s};
            end
        endcase
        if (neg) s = {"-", s};
        return s;
    endfunction

    // Stimulus: directed corner fields first, then random fields.
    initial begin
        int          shape;
        bit          hold;
        logic [2:0]  k;
        logic [7:0]  ch;
        queue_text("", KIND_U8, 0, 0, 0);
        queue_text("-", KIND_I8, 0, 0, 0);
        queue_text("255", KIND_U8, 0, 0, 0);
        queue_text("256", KIND_U8, 0, 0, 0);
        queue_text("-127", KIND_I8, 0, 0, 0);
        queue_text("-0", KIND_I16, 0, 0, 0);
        queue_text("5-", KIND_I32, 0, 0, 0);
        queue_text("-5", KIND_U32, 0, 0, 0);
        queue_text("a", KIND_U64, 0, 0, 0);
        queue_text("-x", KIND_I8, 0, 0, 0);
        // A blank first item still fixes the kind; the digit's own kind is ignored.
        field_items.push_back(make_item(8'($urandom), 1'b0));
        field_items.push_back(make_item(CHAR_NINE, 1'b1));
        commit_field(KIND_I64, 0);

        hold = 1'b1;
        while (pending_chars.size() < 520) begin
            k = 3'($urandom_range(0, 7));
            shape = $urandom_range(0, 19);
            if (shape < 13) begin
                queue_text(number_text(k), k, 0, 0, hold);
            end else if (shape < 15) begin
                queue_text(number_text(k), k, 1, 0, hold);
            end else if (shape < 17) begin
                queue_text(number_text(k), k, $urandom_range(0, 1), 1, hold);
            end else begin
                // Noise: digits, minus signs and arbitrary bytes, some without a character.
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 5))
                        0, 1:    ch = CHAR_ZERO + 8'($urandom_range(0, 9));
                        2:       ch = CHAR_MINUS;
                        default: ch = 8'($urandom);
                    endcase
                    field_items.push_back(make_item(ch, $urandom_range(0, 4) != 0));
                end
                commit_field(k, hold);
            end
            hold = ($urandom_range(0, 29) == 0);
        end

        @(posedge clk);
        while (!rst_n) @(posedge clk);
        @(negedge clk);
        while (pending_chars.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Sender: bursts of transfers with random gaps; a held item waits for all results.
    always @(posedge clk) begin
        queued_char_t nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) convert_char(cur_item);
            if (!s_tvalid || s_tready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() > 0 &&
                             !(pending_chars[0].hold && expected_results.size() > 0)) begin
                    nxt = pending_chars.pop_front();
                    cur_item = nxt.item;
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.item.char_code;
                    s_tuser <= {nxt.item.target_kind, nxt.item.has_char};
                    s_tlast <= nxt.item.last;
                    burst_left--;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transfer, then pick tready from the current stall mode.
    always @(posedge clk) begin
        conv_result_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: value %h ok %b err %0d",
                             $time, m_tdata, m_tuser[0], m_tuser[2:1]);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.ok) begin
                        $display("%0t: ok expected %b actual %b", $time, want.ok, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[2:1] !== want.err) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.err, m_tuser[2:1]);
                        mismatches++;
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (stall_tick % 4 == 0);
                default: m_tready <= (stall_tick % 32 >= 24);
            endcase
        end
    end

    // Watchdog: too long without a transfer on either side ends the run.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
